// ===== rtl/sfc_pkg.sv =====
package sfc_pkg;

  // depth of the tap store and of the sample history
  localparam int MAX_TAPS = 64;
  localparam int ADDR_W   = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // data widths
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);
  localparam int FRAC_SH  = SAMPLE_W - 1;
  localparam int QW       = ACC_W - FRAC_SH;

  // configuration port
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;
  localparam int TAPCNT_W = 7;
  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = TAPCNT_W'(1);
  localparam logic [PADDR_W-1:0]  REG_TAP_COUNT   = PADDR_W'(0);

  // request kinds
  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WRAP = 3'b100
  } state_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

// ===== rtl/sfc_mac.sv =====
module sfc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  sfc_pkg::mac_ctl_t                   ctl,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0] coef,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0] sample,
  output logic signed [sfc_pkg::ACC_W-1:0]    acc,
  output logic                                busy
);

  logic signed [sfc_pkg::PROD_W-1:0] prod;
  logic                              prod_valid;

  // product register
  always_ff @(posedge clk) begin
    prod <= coef * sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.valid && !ctl.clear;
    end
  end

  // accumulator, exact over all taps
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + sfc_pkg::ACC_W'(prod);
    end
  end

  assign busy = prod_valid;

endmodule

// ===== rtl/streaming_fir_convolution_unit.sv =====
// Direct-form FIR filter over a continuous sample stream. A coefficient request
// (req_type 0) writes one tap and the block stays ready. A sample request
// (req_type 1) enters the history line and yields one output: the sum of tap
// times delayed sample over tap_count taps (0 acts as 1, values above 64 act as
// 64), rounded half up from Q8.30 to Q1.15 and saturated, with overflow set when
// saturated and segment_last echoed. One shared 16x16 multiply-accumulate walks
// the taps one per cycle, so a sample holds in_stall high while the taps in use
// are walked and the read, product and accumulate stages drain after the last
// tap, and its result is registered at the end of that time; a previous result
// still stalled in the output register adds the time it waits. A finished result
// may wait in the output register while the next request is taken. Load every
// tap below tap_count before feeding samples. The history starts as zeros after
// reset through a fill count, so no clearing pass is needed. tap_count is written
// over the APB port, whose decode matches every address; write it only while the
// block is idle, which the block itself does not enforce.
module streaming_fir_convolution_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfc_pkg::PADDR_W-1:0]         paddr,
  input  logic [sfc_pkg::PDATA_W-1:0]         pwdata,
  output logic [sfc_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [5:0]                          coef_index,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0] coef_value,
  input  logic signed [sfc_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                segment_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sfc_pkg::SAMPLE_W-1:0] filtered_sample,
  output logic                                overflow,
  output logic                                segment_last_res
);

  sfc_pkg::state_t state, state_next;

  logic [sfc_pkg::TAPCNT_W-1:0]       tap_count;
  logic [sfc_pkg::CNT_W-1:0]          taps_in_use;
  logic [sfc_pkg::CNT_W-1:0]          taps_n;
  logic [sfc_pkg::CNT_W-1:0]          fill;
  logic [sfc_pkg::CNT_W-1:0]          k;
  logic [sfc_pkg::ADDR_W-1:0]         wp;
  logic [sfc_pkg::ADDR_W-1:0]         wp_inc;
  logic [sfc_pkg::ADDR_W-1:0]         rd_ptr;
  logic                               seg;
  logic                               in_accept;
  logic                               sample_acc;
  logic                               coef_wr;
  logic                               last_tap;
  logic                               s1_valid;
  logic                               s1_live;
  logic                               wrap_done;
  logic signed [sfc_pkg::SAMPLE_W-1:0] tap_mem [sfc_pkg::MAX_TAPS];
  logic signed [sfc_pkg::SAMPLE_W-1:0] hist_mem [sfc_pkg::MAX_TAPS];
  logic signed [sfc_pkg::SAMPLE_W-1:0] tap_rd;
  logic signed [sfc_pkg::SAMPLE_W-1:0] hist_rd;
  logic signed [sfc_pkg::SAMPLE_W-1:0] mac_sample;
  logic signed [sfc_pkg::ACC_W-1:0]    acc;
  logic signed [sfc_pkg::ACC_W-1:0]    rounded;
  logic signed [sfc_pkg::QW-1:0]       q;
  logic                                q_hi;
  logic                                q_lo;
  logic                                mac_busy;
  sfc_pkg::mac_ctl_t                   mac_ctl;

  // configuration register
  assign pready = 1'b1;
  assign prdata = sfc_pkg::PDATA_W'(tap_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= sfc_pkg::TAP_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr >> 2) == (sfc_pkg::REG_TAP_COUNT >> 2)) begin
      tap_count <= pwdata[sfc_pkg::TAPCNT_W-1:0];
    end
  end

  // clamp the tap count to 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      taps_in_use = sfc_pkg::CNT_W'(1);
    end else if (32'(tap_count) > 32'(sfc_pkg::MAX_TAPS)) begin
      taps_in_use = sfc_pkg::CNT_W'(sfc_pkg::MAX_TAPS);
    end else begin
      taps_in_use = sfc_pkg::CNT_W'(tap_count);
    end
  end

  // request decode
  assign in_stall   = (state != sfc_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign sample_acc = in_accept && (req_type == sfc_pkg::REQ_SAMPLE);
  assign coef_wr    = in_accept && (req_type == sfc_pkg::REQ_COEF) &&
                      (32'(coef_index) < 32'(sfc_pkg::MAX_TAPS));

  assign wp_inc = (wp == sfc_pkg::ADDR_W'(sfc_pkg::MAX_TAPS - 1)) ? '0 : wp + 1'b1;
  assign last_tap = (k == taps_n - 1'b1);

  // tap store: one write port, one registered read
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      tap_mem[sfc_pkg::ADDR_W'(coef_index)] <= coef_value;
    end
    tap_rd <= tap_mem[k[sfc_pkg::ADDR_W-1:0]];
  end

  // sample history as a circular buffer, newest at wp
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      hist_mem[wp_inc] <= sample_value;
    end
    hist_rd <= hist_mem[rd_ptr];
  end

  // history pointer and fill count; entries at or past fill read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (sample_acc) begin
      wp <= wp_inc;
      if (fill != sfc_pkg::CNT_W'(sfc_pkg::MAX_TAPS)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // tap walk counters
  always_ff @(posedge clk) begin
    if (sample_acc) begin
      k      <= '0;
      rd_ptr <= wp_inc;
      taps_n <= taps_in_use;
      seg    <= segment_last;
    end else if (state == sfc_pkg::ST_RUN) begin
      k      <= k + 1'b1;
      rd_ptr <= (rd_ptr == '0) ? sfc_pkg::ADDR_W'(sfc_pkg::MAX_TAPS - 1) : rd_ptr - 1'b1;
    end
  end

  // read stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == sfc_pkg::ST_RUN);
    end
    s1_live <= (k < fill);
  end

  // shared multiply-accumulate
  assign mac_ctl.clear = sample_acc;
  assign mac_ctl.valid = s1_valid;
  assign mac_sample    = s1_live ? hist_rd : '0;

  sfc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .coef   (tap_rd),
    .sample (mac_sample),
    .acc    (acc),
    .busy   (mac_busy)
  );

  // round half up to Q1.15 and saturate
  assign rounded = acc + sfc_pkg::ACC_W'(1 << (sfc_pkg::FRAC_SH - 1));
  assign q       = sfc_pkg::QW'(rounded >>> sfc_pkg::FRAC_SH);
  assign q_hi    = (q > sfc_pkg::QW'(32767));
  assign q_lo    = (q < -sfc_pkg::QW'(32768));

  assign wrap_done = (state == sfc_pkg::ST_WRAP) && !s1_valid && !mac_busy &&
                     (!out_valid || !out_stall);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      sfc_pkg::ST_IDLE: begin
        if (sample_acc) state_next = sfc_pkg::ST_RUN;
      end
      sfc_pkg::ST_RUN: begin
        if (last_tap) state_next = sfc_pkg::ST_WRAP;
      end
      sfc_pkg::ST_WRAP: begin
        if (wrap_done) state_next = sfc_pkg::ST_IDLE;
      end
      default: state_next = sfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wrap_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap_done) begin
      if (q_hi) begin
        filtered_sample <= 16'sh7fff;
      end else if (q_lo) begin
        filtered_sample <= 16'sh8000;
      end else begin
        filtered_sample <= q[sfc_pkg::SAMPLE_W-1:0];
      end
      overflow         <= q_hi || q_lo;
      segment_last_res <= seg;
    end
  end

endmodule

// ===== rtl/sfc_checker.sv =====
module sfc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                req_type,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [sfc_pkg::SAMPLE_W-1:0] filtered_sample,
  input logic                                overflow
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_sample) && $stable(overflow))
    else $error("stalled result changed");

  // a sample request occupies the block
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == sfc_pkg::REQ_SAMPLE |=> in_stall)
    else $error("block ready right after a sample request");

  // a coefficient request leaves the block ready
  a_coef_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == sfc_pkg::REQ_COEF |=> !in_stall)
    else $error("block busy after a coefficient request");

  // overflow only with a rail value
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> filtered_sample == 16'sh7fff || filtered_sample == 16'sh8000)
    else $error("overflow without saturated output");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind streaming_fir_convolution_unit sfc_checker u_sfc_checker (.*);
